/* hw/rtl/orsb_pkg.sv */
package orsb_pkg;

    // Ring geometry
    localparam int DEPTH   = 64;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int FILL_W  = 7;
    localparam int WORD_W  = 32;

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    // Request codes on the input channel
    localparam logic [1:0] REQ_PUSH   = 2'd0;
    localparam logic [1:0] REQ_NEWEST = 2'd1;
    localparam logic [1:0] REQ_ALL    = 2'd2;
    localparam logic [1:0] REQ_COUNT  = 2'd3;

    // Command kinds handed to the back end
    localparam logic [1:0] K_PUSH = 2'd0;
    localparam logic [1:0] K_READ = 2'd1;
    localparam logic [1:0] K_ZERO = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] stamp;
        logic [WORD_W-1:0] accel_x;
        logic [WORD_W-1:0] accel_y;
        logic [WORD_W-1:0] accel_z;
        logic [WORD_W-1:0] gyro_x;
        logic [WORD_W-1:0] gyro_y;
        logic [WORD_W-1:0] gyro_z;
    } t_rec;

    typedef struct packed {
        logic [1:0]    kind;
        logic [AW-1:0] addr;
        logic [CW-1:0] cnt;
        logic [CW-1:0] fill;
        t_rec          rec;
    } t_cmd;

endpackage

/* hw/rtl/orsb_queue.sv */
module orsb_queue
    import orsb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_avail,
    output t_cmd o_cmd
);

    t_cmd            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wp;
    logic [QAW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;
    logic [QAW-1:0]  n_wp;
    logic [QAW-1:0]  n_rp;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Wrap the queue pointers
    always_comb begin
        n_wp = (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp = (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
    end

    // Hold commands in order
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (i_pop) begin
                r_rp <= n_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/orsb_front.sv */
module orsb_front
    import orsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  t_rec        i_rec,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    localparam logic [CW:0] DEPTH_X = (CW + 1)'(DEPTH);

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic [AW-1:0] head_prev;
    logic [CW:0]   start_raw;
    logic [AW-1:0] start;
    logic          accept;
    logic          empty;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign o_q_push = accept;
    assign empty    = (r_count == '0);

    // Ring arithmetic on the head
    always_comb begin
        n_head    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
        n_count   = (r_count == CW'(DEPTH)) ? r_count : r_count + 1'b1;
        start_raw = (CW + 1)'(r_head) + DEPTH_X - (CW + 1)'(r_count);
        if (start_raw >= DEPTH_X) begin
            start_raw = start_raw - DEPTH_X;
        end
        start = start_raw[AW-1:0];
    end

    // Classify the request into a back-end command
    always_comb begin
        o_q_cmd      = '0;
        o_q_cmd.rec  = i_rec;
        o_q_cmd.fill = r_count;
        o_q_cmd.cnt  = CW'(1);
        case (i_req_type)
            REQ_PUSH: begin
                o_q_cmd.kind = K_PUSH;
                o_q_cmd.addr = r_head;
            end
            REQ_NEWEST: begin
                o_q_cmd.kind = empty ? K_ZERO : K_READ;
                o_q_cmd.addr = head_prev;
            end
            REQ_ALL: begin
                o_q_cmd.kind = empty ? K_ZERO : K_READ;
                o_q_cmd.addr = start;
                o_q_cmd.cnt  = empty ? CW'(1) : r_count;
            end
            default: begin
                o_q_cmd.kind = K_ZERO;
            end
        endcase
    end

    // Advance head and saturate count on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (accept && (i_req_type == REQ_PUSH)) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/orsb_back.sv */
module orsb_back
    import orsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_avail,
    input  t_cmd              i_q_cmd,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output t_rec              o_rec,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_last
);

    t_rec          r_mem [DEPTH];

    // Sequencer
    logic          r_busy;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_fill;
    logic          r_zero;

    // Read stage
    logic          r_rd_vld;
    t_rec          r_rd_data;
    logic          r_rd_last;
    logic [CW-1:0] r_rd_fill;
    logic          r_rd_zero;

    // Output register
    logic          r_out_vld;
    t_rec          r_out_rec;
    logic          r_out_found;
    logic [CW-1:0] r_out_fill;
    logic          r_out_last;

    logic          out_load;
    logic          rd_free;
    logic          issue;
    logic          wr_en;
    logic          seq_last;
    logic [AW-1:0] n_addr;

    assign out_load = r_rd_vld && (!r_out_vld || i_ready);
    assign rd_free  = !r_rd_vld || out_load;
    assign issue    = r_busy && rd_free;
    assign o_q_pop  = i_q_avail && !r_busy;
    assign wr_en    = o_q_pop && (i_q_cmd.kind == K_PUSH);
    assign seq_last = (r_rem == CW'(1));
    assign n_addr   = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + 1'b1;

    // Write pushed records, read one entry per issue
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_q_cmd.addr] <= i_q_cmd.rec;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    // Step through the records of a read request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_pop && (i_q_cmd.kind != K_PUSH)) begin
            r_busy <= 1'b1;
        end else if (issue && seq_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_addr <= i_q_cmd.addr;
            r_rem  <= i_q_cmd.cnt;
            r_fill <= i_q_cmd.fill;
            r_zero <= (i_q_cmd.kind == K_ZERO);
        end else if (issue) begin
            r_addr <= n_addr;
            r_rem  <= r_rem - 1'b1;
        end
    end

    // Track the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (issue) begin
            r_rd_vld <= 1'b1;
        end else if (out_load) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_last <= seq_last;
            r_rd_fill <= r_fill;
            r_rd_zero <= r_zero;
        end
    end

    // Load the output register, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rec   <= r_rd_zero ? '0 : r_rd_data;
            r_out_found <= !r_rd_zero;
            r_out_fill  <= r_rd_fill;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_rec        = r_out_rec;
    assign o_found      = r_out_found;
    assign o_fill_count = FILL_W'(r_out_fill);
    assign o_last       = r_out_last;

endmodule

/* hw/rtl/overwrite_ring_sample_buffer_core.sv */
// Channel   Dir  Handshake          Payload
// request   in   i_valid / o_ready  i_req_type, i_stamp, i_accel_*, i_gyro_*
// result    out  o_valid / i_ready  o_found, o_out_*, o_fill_count, o_last
//
// Pushes and reads enter a two-entry command queue. A dequeued push writes the
// record memory; a read loads the sequencer, which issues one record per cycle
// unless a stalled result backs up the read stage, through the memory read stage
// and output register, and takes no new command until its last record has issued.
// Reset (synchronous, active low) clears head, count, queue and all valid flags;
// the record memory is not cleared. A stalled result holds the output register and
// backs up the read stage, the queue and finally o_ready.
module overwrite_ring_sample_buffer_core
    import orsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_req_type,
    input  logic [31:0]       i_stamp,
    input  logic [31:0]       i_accel_x,
    input  logic [31:0]       i_accel_y,
    input  logic [31:0]       i_accel_z,
    input  logic [31:0]       i_gyro_x,
    input  logic [31:0]       i_gyro_y,
    input  logic [31:0]       i_gyro_z,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_found,
    output logic [31:0]       o_out_stamp,
    output logic [31:0]       o_out_accel_x,
    output logic [31:0]       o_out_accel_y,
    output logic [31:0]       o_out_accel_z,
    output logic [31:0]       o_out_gyro_x,
    output logic [31:0]       o_out_gyro_y,
    output logic [31:0]       o_out_gyro_z,
    output logic [FILL_W-1:0] o_fill_count,
    output logic              o_last
);

    t_rec in_rec;
    t_rec out_rec;
    t_cmd q_in_cmd;
    t_cmd q_out_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_avail;

    // Pack the pushed record
    always_comb begin
        in_rec.stamp   = i_stamp;
        in_rec.accel_x = i_accel_x;
        in_rec.accel_y = i_accel_y;
        in_rec.accel_z = i_accel_z;
        in_rec.gyro_x  = i_gyro_x;
        in_rec.gyro_y  = i_gyro_y;
        in_rec.gyro_z  = i_gyro_z;
    end

    orsb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_rec      (in_rec),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    orsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_cmd   (q_out_cmd)
    );

    orsb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_avail    (q_avail),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_found      (o_found),
        .o_rec        (out_rec),
        .o_fill_count (o_fill_count),
        .o_last       (o_last)
    );

    // Unpack the returned record
    assign o_out_stamp   = out_rec.stamp;
    assign o_out_accel_x = out_rec.accel_x;
    assign o_out_accel_y = out_rec.accel_y;
    assign o_out_accel_z = out_rec.accel_z;
    assign o_out_gyro_x  = out_rec.gyro_x;
    assign o_out_gyro_y  = out_rec.gyro_y;
    assign o_out_gyro_z  = out_rec.gyro_z;

endmodule

/* hw/rtl/orsb_checker.sv */
module orsb_checker
    import orsb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_ready,
    input logic              o_valid,
    input logic              o_found,
    input logic [31:0]       o_out_stamp,
    input logic [FILL_W-1:0] o_fill_count,
    input logic              o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_stamp) && $stable(o_last))
        else $error("result changed while stalled");

    // An empty or count result is always the only one of its request
    a_zero_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_last)
        else $error("record-less result not marked last");

    // A record result implies a nonempty buffer within depth
    a_found_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_fill_count != '0) && (o_fill_count <= FILL_W'(DEPTH)))
        else $error("record result with bad fill count");

    // A non-final result belongs to a read-all of two or more records
    a_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_found && (o_fill_count > FILL_W'(1)))
        else $error("non-final result outside a multi-record read");

endmodule

bind overwrite_ring_sample_buffer_core orsb_checker u_orsb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_ready      (i_ready),
    .o_valid      (o_valid),
    .o_found      (o_found),
    .o_out_stamp  (o_out_stamp),
    .o_fill_count (o_fill_count),
    .o_last       (o_last)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import orsb_pkg::*;
();

    localparam int N_RANDOM     = 300;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [1:0] kind;
        t_rec       rec;
        int         gap;
    } t_sensor_req;

    typedef struct packed {
        logic              found;
        t_rec              rec;
        logic [FILL_W-1:0] fill;
        logic              last;
    } t_ring_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_req_type = REQ_PUSH;
    logic [31:0]       i_stamp = '0;
    logic [31:0]       i_accel_x = '0;
    logic [31:0]       i_accel_y = '0;
    logic [31:0]       i_accel_z = '0;
    logic [31:0]       i_gyro_x = '0;
    logic [31:0]       i_gyro_y = '0;
    logic [31:0]       i_gyro_z = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_found;
    logic [31:0]       o_out_stamp;
    logic [31:0]       o_out_accel_x;
    logic [31:0]       o_out_accel_y;
    logic [31:0]       o_out_accel_z;
    logic [31:0]       o_out_gyro_x;
    logic [31:0]       o_out_gyro_y;
    logic [31:0]       o_out_gyro_z;
    logic [FILL_W-1:0] o_fill_count;
    logic              o_last;

    overwrite_ring_sample_buffer_core DUT (.*);

    // Predictor state: shadow ring, head and occupancy
    t_rec          ring_shadow [DEPTH];
    logic [AW-1:0] shadow_head = '0;
    logic [CW-1:0] shadow_held = '0;

    t_sensor_req   pending_reqs[$];
    t_ring_result  expected_results[$];
    int            accepted_reqs = 0;
    int            total_reqs = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Advance the shadow ring by one request and queue the results it causes
    task automatic predict_ring_response(input t_sensor_req rq);
        t_ring_result r;
        int           first;
        r = '0;
        r.last = 1'b1;
        r.fill = FILL_W'(shadow_held);
        case (rq.kind)
            REQ_PUSH: begin
                ring_shadow[shadow_head] = rq.rec;
                shadow_head = (shadow_head == AW'(DEPTH - 1)) ? '0 : shadow_head + 1'b1;
                if (shadow_held < CW'(DEPTH))
                    shadow_held = shadow_held + 1'b1;
            end
            REQ_NEWEST: begin
                if (shadow_held != 0) begin
                    r.found = 1'b1;
                    r.rec = ring_shadow[(int'(shadow_head) + DEPTH - 1) % DEPTH];
                end
                expected_results.push_back(r);
            end
            REQ_ALL: begin
                if (shadow_held == 0) begin
                    expected_results.push_back(r);
                end else begin
                    first = (int'(shadow_head) + DEPTH - int'(shadow_held)) % DEPTH;
                    r.found = 1'b1;
                    for (int i = 0; i < int'(shadow_held); i++) begin
                        r.rec = ring_shadow[(first + i) % DEPTH];
                        r.last = (i == int'(shadow_held) - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                expected_results.push_back(r);
            end
        endcase
    endtask

    function automatic t_rec random_record();
        t_rec rec;
        rec = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return rec;
    endfunction

    function automatic t_sensor_req make_req(input logic [1:0] kind, input t_rec rec,
                                             input int gap);
        t_sensor_req rq;
        rq.kind = kind;
        rq.rec = rec;
        rq.gap = gap;
        return rq;
    endfunction

    // Driver: offer pending requests, holding each until the block takes it
    int gap_left = -1;
    always @(posedge i_clk) begin
        t_sensor_req rq;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left = -1;
        end else begin
            if (i_valid && o_ready) begin
                predict_ring_response(make_req(i_req_type,
                    {i_stamp, i_accel_x, i_accel_y, i_accel_z, i_gyro_x, i_gyro_y, i_gyro_z},
                    0));
                accepted_reqs++;
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 && gap_left < 0)
                    gap_left = pending_reqs[0].gap;
                if (pending_reqs.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    rq = pending_reqs.pop_front();
                    gap_left = -1;
                    i_valid    <= 1'b1;
                    i_req_type <= rq.kind;
                    {i_stamp, i_accel_x, i_accel_y, i_accel_z,
                     i_gyro_x, i_gyro_y, i_gyro_z} <= rq.rec;
                end
            end
        end
    end

    // Monitor: check each taken result and pace i_ready
    int  stall_left = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge i_clk) begin
        t_ring_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result stamp", o_out_stamp, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_found !== want.found)
                        report_mismatch("found", 32'(o_found), 32'(want.found));
                    if (o_out_stamp !== want.rec.stamp)
                        report_mismatch("stamp", o_out_stamp, want.rec.stamp);
                    if (o_out_accel_x !== want.rec.accel_x)
                        report_mismatch("accel_x", o_out_accel_x, want.rec.accel_x);
                    if (o_out_accel_y !== want.rec.accel_y)
                        report_mismatch("accel_y", o_out_accel_y, want.rec.accel_y);
                    if (o_out_accel_z !== want.rec.accel_z)
                        report_mismatch("accel_z", o_out_accel_z, want.rec.accel_z);
                    if (o_out_gyro_x !== want.rec.gyro_x)
                        report_mismatch("gyro_x", o_out_gyro_x, want.rec.gyro_x);
                    if (o_out_gyro_y !== want.rec.gyro_y)
                        report_mismatch("gyro_y", o_out_gyro_y, want.rec.gyro_y);
                    if (o_out_gyro_z !== want.rec.gyro_z)
                        report_mismatch("gyro_z", o_out_gyro_z, want.rec.gyro_z);
                    if (o_fill_count !== want.fill)
                        report_mismatch("fill_count", 32'(o_fill_count), 32'(want.fill));
                    if (o_last !== want.last)
                        report_mismatch("last", 32'(o_last), 32'(want.last));
                end
                results_seen++;
                // no stall for a stretch of results, random stall otherwise
                stall_left = ((results_seen % 160) < 40) ? 0 : $urandom_range(0, 4);
            end
            // one long hold-off so the block backs up and drops o_ready
            if (!long_hold_done && accepted_reqs >= HOLD_AT) begin
                long_hold_done = 1'b1;
                long_hold_left = HOLD_CYCLES;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no request or result moves for too long
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        t_rec zero_rec;
        int   pick;
        int   gap;
        logic [1:0] kind;
        zero_rec = '0;

        // Directed: empty-buffer reads, field extremes, one and several records
        pending_reqs.push_back(make_req(REQ_NEWEST, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_ALL, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_COUNT, random_record(), 1));
        pending_reqs.push_back(make_req(REQ_PUSH, ~zero_rec, 0));
        pending_reqs.push_back(make_req(REQ_NEWEST, zero_rec, 0));
        pending_reqs.push_back(make_req(REQ_ALL, zero_rec, 2));
        pending_reqs.push_back(make_req(REQ_COUNT, ~zero_rec, 0));
        pending_reqs.push_back(make_req(REQ_PUSH, zero_rec, 0));
        pending_reqs.push_back(make_req(REQ_NEWEST, ~zero_rec, 0));
        pending_reqs.push_back(make_req(REQ_ALL, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_PUSH, {7{32'hAAAA_AAAA}}, 3));
        pending_reqs.push_back(make_req(REQ_PUSH, {7{32'h5555_5555}}, 0));
        pending_reqs.push_back(make_req(REQ_NEWEST, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_ALL, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_COUNT, random_record(), 4));
        pending_reqs.push_back(make_req(REQ_PUSH, random_record(), 0));
        pending_reqs.push_back(make_req(REQ_ALL, random_record(), 0));

        // Random: mostly pushes so the ring fills, wraps and overwrites
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                kind = REQ_PUSH;
            else if (pick < 72)
                kind = REQ_NEWEST;
            else if (pick < 82)
                kind = REQ_ALL;
            else
                kind = REQ_COUNT;
            gap = ((n % 80) < 20) ? 0 : $urandom_range(0, 4);
            pending_reqs.push_back(make_req(kind, random_record(), gap));
        end
        total_reqs = pending_reqs.size();

        // Hold reset, then release it at a rising edge
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every result to drain
        @(negedge i_clk);
        while (!(accepted_reqs == total_reqs && expected_results.size() == 0))
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
